>>> hw/rtl/assert_macros.svh
// assertion helpers for concurrent checks on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam logic [7:0] HDR_A         = 8'hCC;
  localparam logic [7:0] HDR_B         = 8'h81;
  localparam logic [7:0] TAIL_A        = 8'h0D;
  localparam logic [7:0] TAIL_B        = 8'h0A;
  localparam logic [7:0] TYPE_RANGE    = 8'h0F;
  localparam logic [7:0] TYPE_SPECTRUM = 8'h02;

  localparam logic [23:0] MIN_LEN          = 24'd9;
  localparam logic [23:0] MIN_SPECTRUM_LEN = 24'd124;

  localparam logic [23:0] POS_LENGTH_LAST = 24'd4;
  localparam logic [23:0] POS_TYPE        = 24'd5;
  localparam logic [23:0] POS_EXP_STATE   = 24'd6;
  localparam logic [23:0] POS_RANGE_START = 24'd7;
  localparam logic [23:0] POS_RANGE_END   = 24'd9;
  localparam logic [23:0] POS_EXP_TIME    = 24'd10;
  localparam logic [23:0] POS_PARAM_FIRST = 24'd11;
  localparam logic [23:0] POS_PARAM_LAST  = 24'd118;
  localparam logic [23:0] POS_COEF        = 24'd120;
  localparam logic [23:0] POS_SAMPLE_BASE = 24'd122;
  localparam logic [24:0] POS_CHECKSUM_BASE = 25'd121;
  localparam logic [22:0] PARAM_COUNT     = 23'd27;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_FRAME
  } phase_t;

  typedef enum logic [3:0] {
    KIND_RANGE_START,
    KIND_RANGE_END,
    KIND_EXP_STATE,
    KIND_EXP_TIME,
    KIND_PARAM,
    KIND_COEF,
    KIND_SAMPLE,
    KIND_CHECKSUM,
    KIND_FRAME_END
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_TAIL,
    STATUS_UNKNOWN_TYPE,
    STATUS_BAD_LENGTH
  } status_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [22:0] index;
    logic [31:0] value;
    status_t     status;
    logic [15:0] peak;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/spectrometer_frame_deframer_top.sv
// channel  | handshake           | payload
// input    | in_valid, in_stall  | rx_byte
// output   | out_valid, out_stall| kind, item_index, field_value, frame_status, peak_sample
//
// one byte per cycle while no held result stalls the output; an accepted byte passes through
// the input register, single-pass parse logic and the result register
// rst is synchronous: clears the hunt state and empties both registers
// a stalled result holds the result register; the input register still takes one byte
`default_nettype none
`include "assert_macros.svh"
module spectrometer_frame_deframer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output sfd_pkg::kind_t   kind,
  output logic [22:0]      item_index,
  output logic [31:0]      field_value,
  output sfd_pkg::status_t frame_status,
  output logic [15:0]      peak_sample
);
  import sfd_pkg::*;

  logic       q_valid;
  logic [7:0] q_byte;
  logic       out_ready;
  logic       advance;
  res_t       res;

  assign advance = q_valid && out_ready;

  sfd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  sfd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .b    (q_byte),
    .res  (res)
  );

  sfd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .item_index   (item_index),
    .field_value  (field_value),
    .frame_status (frame_status),
    .peak_sample  (peak_sample)
  );

  // input backs up only behind a held result
  `SFD_ASSERT_IMPLY(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // status and peak only on frame end
  `SFD_ASSERT_IMPLY(a_end_only, clk, rst, out_valid && kind != KIND_FRAME_END,
                    frame_status == STATUS_OK && peak_sample == 16'd0)
  // parameter numbers stay in range
  `SFD_ASSERT_IMPLY(a_param_idx, clk, rst, out_valid && kind == KIND_PARAM,
                    item_index < PARAM_COUNT)
  // a held input byte moves on once the result side frees up
  `SFD_ASSERT_NEXT(a_drain, clk, rst, in_stall && !out_stall, !in_stall)

endmodule
`default_nettype wire

>>> hw/rtl/sfd_in_reg.sv
`default_nettype none
module sfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  logic accept;

  assign in_stall = q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sfd_parse.sv
`default_nettype none
module sfd_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    b,
  output sfd_pkg::res_t res
);
  import sfd_pkg::*;

  phase_t      phase, phase_next;
  logic [23:0] byte_position, byte_position_next;
  logic [23:0] frame_length, frame_length_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [31:0] field_shift, field_shift_next;
  logic [22:0] field_count, field_count_next;
  logic [15:0] peak_value, peak_value_next;
  logic [7:0]  prior_byte;

  logic [23:0] pos_inc;
  logic [31:0] shift_new;
  logic        is_last;
  logic        len_bad;
  logic [24:0] pos_wide;
  logic [24:0] chk_pos;
  logic [23:0] param_off;
  logic [23:0] samp_off;
  logic [23:0] len_diff;
  logic [15:0] upper_half;

  assign pos_inc    = byte_position + 24'd1;
  assign shift_new  = {b, field_shift[31:8]};
  assign upper_half = shift_new[31:16];
  assign is_last    = (pos_inc == frame_length);
  assign len_bad    = (frame_length < MIN_LEN) ||
                      ((b == TYPE_SPECTRUM) && (frame_length < MIN_SPECTRUM_LEN));
  assign pos_wide   = {1'b0, byte_position};
  assign chk_pos    = POS_CHECKSUM_BASE + {1'b0, field_count, 1'b0};
  assign param_off  = byte_position - POS_PARAM_FIRST;
  assign samp_off   = byte_position - POS_SAMPLE_BASE;
  assign len_diff   = frame_length - MIN_SPECTRUM_LEN;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT_FIRST: begin
        if (b == HDR_A) begin
          phase_next = PH_HUNT_SECOND;
        end
      end
      PH_HUNT_SECOND: begin
        if (b == HDR_B) begin
          phase_next = PH_FRAME;
        end else if (b != HDR_A) begin
          phase_next = PH_HUNT_FIRST;
        end
      end
      PH_FRAME: begin
        if ((byte_position == POS_TYPE && len_bad) ||
            (byte_position > POS_TYPE && is_last)) begin
          phase_next = PH_HUNT_FIRST;
        end
      end
      default: phase_next = PH_HUNT_FIRST;
    endcase
  end

  // frame registers and result
  always_comb begin
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    frame_type_next    = frame_type;
    field_shift_next   = field_shift;
    field_count_next   = field_count;
    peak_value_next    = peak_value;
    res                = '0;
    case (phase)
      PH_HUNT_FIRST: begin
      end
      PH_HUNT_SECOND: begin
        if (b == HDR_B) begin
          byte_position_next = 24'd2;
          frame_length_next  = '0;
          frame_type_next    = '0;
          field_shift_next   = '0;
          field_count_next   = '0;
          peak_value_next    = '0;
        end
      end
      PH_FRAME: begin
        byte_position_next = pos_inc;
        field_shift_next   = shift_new;
        if (byte_position == POS_LENGTH_LAST) begin
          frame_length_next = shift_new[31:8];
        end
        if (byte_position == POS_TYPE) begin
          frame_type_next = b;
          if (len_bad) begin
            res.valid  = 1'b1;
            res.kind   = KIND_FRAME_END;
            res.status = STATUS_BAD_LENGTH;
          end else if (b == TYPE_SPECTRUM) begin
            field_count_next = len_diff[23:1];
          end
        end else if (byte_position > POS_TYPE) begin
          if (is_last) begin
            res.valid = 1'b1;
            res.kind  = KIND_FRAME_END;
            res.peak  = peak_value;
            if (prior_byte != TAIL_A || b != TAIL_B) begin
              res.status = STATUS_BAD_TAIL;
            end else if (frame_type == TYPE_RANGE || frame_type == TYPE_SPECTRUM) begin
              res.status = STATUS_OK;
            end else begin
              res.status = STATUS_UNKNOWN_TYPE;
            end
          end else if (frame_type == TYPE_RANGE) begin
            if (byte_position == POS_RANGE_START) begin
              res.valid = 1'b1;
              res.kind  = KIND_RANGE_START;
              res.value = {16'd0, upper_half};
            end else if (byte_position == POS_RANGE_END) begin
              res.valid = 1'b1;
              res.kind  = KIND_RANGE_END;
              res.value = {16'd0, upper_half};
            end
          end else if (frame_type == TYPE_SPECTRUM) begin
            if (byte_position == POS_EXP_STATE) begin
              res.valid = 1'b1;
              res.kind  = KIND_EXP_STATE;
              res.value = {24'd0, b};
            end else if (byte_position == POS_EXP_TIME) begin
              res.valid = 1'b1;
              res.kind  = KIND_EXP_TIME;
              res.value = shift_new;
            end else if (byte_position inside {[POS_PARAM_FIRST:POS_PARAM_LAST]}) begin
              if (param_off[1:0] == 2'd3) begin
                res.valid = 1'b1;
                res.kind  = KIND_PARAM;
                res.index = {1'b0, param_off[23:2]};
                res.value = shift_new;
              end
            end else if (byte_position == POS_COEF) begin
              res.valid = 1'b1;
              res.kind  = KIND_COEF;
              res.value = {16'd0, upper_half};
            end else if (pos_wide == chk_pos) begin
              res.valid = 1'b1;
              res.kind  = KIND_CHECKSUM;
              res.value = {24'd0, b};
            end else if (byte_position >= POS_SAMPLE_BASE && pos_wide < chk_pos &&
                         !samp_off[0]) begin
              res.valid = 1'b1;
              res.kind  = KIND_SAMPLE;
              res.index = samp_off[23:1];
              res.value = {16'd0, upper_half};
              if (upper_half > peak_value) begin
                peak_value_next = upper_half;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT_FIRST;
      byte_position <= '0;
      frame_length  <= '0;
      frame_type    <= '0;
      field_shift   <= '0;
      field_count   <= '0;
      peak_value    <= '0;
      prior_byte    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      frame_type    <= frame_type_next;
      field_shift   <= field_shift_next;
      field_count   <= field_count_next;
      peak_value    <= peak_value_next;
      prior_byte    <= b;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sfd_out_reg.sv
`default_nettype none
module sfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  sfd_pkg::res_t    res,
  output logic             out_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output sfd_pkg::kind_t   kind,
  output logic [22:0]      item_index,
  output logic [31:0]      field_value,
  output sfd_pkg::status_t frame_status,
  output logic [15:0]      peak_sample
);
  import sfd_pkg::*;

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res.valid) begin
      kind         <= res.kind;
      item_index   <= res.index;
      field_value  <= res.value;
      frame_status <= res.status;
      peak_sample  <= res.peak;
    end
  end

endmodule
`default_nettype wire
